// File: rtl/core/cas_pkg.sv
// Shared types and codes for the CPU arithmetic step block.
// Depends on nothing; used by every module in rtl/core.
package cas_pkg;

  // Operation selector codes
  localparam logic [3:0] MODE_ADC    = 4'd0;
  localparam logic [3:0] MODE_SBC    = 4'd1;
  localparam logic [3:0] MODE_CMP    = 4'd2;
  localparam logic [3:0] MODE_CPX    = 4'd3;
  localparam logic [3:0] MODE_CPY    = 4'd4;
  localparam logic [3:0] MODE_INCMEM = 4'd5;
  localparam logic [3:0] MODE_INCACC = 4'd6;
  localparam logic [3:0] MODE_DECMEM = 4'd7;
  localparam logic [3:0] MODE_DECACC = 4'd8;
  localparam logic [3:0] MODE_INX    = 4'd9;
  localparam logic [3:0] MODE_INY    = 4'd10;
  localparam logic [3:0] MODE_DEX    = 4'd11;
  localparam logic [3:0] MODE_DEY    = 4'd12;

  // Status bit positions
  localparam int FLAG_N = 7;
  localparam int FLAG_V = 6;
  localparam int FLAG_D = 3;
  localparam int FLAG_Z = 1;
  localparam int FLAG_C = 0;

  // Largest legal BCD digit and the decimal radix
  localparam logic [3:0] BCD_MAX   = 4'd9;
  localparam logic [4:0] BCD_RADIX = 5'd10;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] operand;
    logic [7:0] reg_in;
    logic [7:0] status_in;
  } op_t;

  typedef struct packed {
    logic [7:0] reg_out;
    logic       reg_write;
    logic [7:0] mem_value;
    logic       mem_write;
    logic [7:0] status_out;
  } res_t;

  // Result of the decimal adder/subtractor
  typedef struct packed {
    logic [7:0] value;
    logic       carry;
    logic       ovf;
    logic       ok;
  } bcd_res_t;

endpackage

// File: rtl/core/cpu_arith_alu_step_top.sv
// Top level of the CPU arithmetic step: input register, ALU, result register.
// Depends on cas_pkg and cas_alu.
//
// Usage
//   One operation goes in on the op channel (op_valid / op_stall / op) and
//   one result comes out on the res channel (res_valid / res_stall / res).
//   A transfer happens on a rising edge where valid is high and stall is low.
//   Every operation gives exactly one result, in order.
//   A result is offered once its operation has passed through the input
//   register and then the result register; a stalled result register
//   can hold an operation in the input register between the two.
//   Throughput: one operation per cycle while op_stall is low; the ALU is a
//   single combinational pass between the input register and the result
//   register, so nothing in the datapath iterates.
//   Stall: while res_stall holds a result, the result register holds it and
//   the input register can still take one more operation; op_stall rises
//   only once both registers are full and the result is not taken.
//   Reset: rst (synchronous, active high) empties both registers; no result
//   is offered and op_stall is low in the cycle after reset.
module cpu_arith_alu_step_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  cas_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_stall,
  output cas_pkg::res_t res
);
  import cas_pkg::*;

  op_t  op_q;
  logic s1_valid;
  res_t alu_res;
  logic out_ready;

  // Result register can load when empty or when its content transfers now
  assign out_ready = ~res_valid | ~res_stall;
  // Hold the input side only when the input register cannot advance
  assign op_stall  = s1_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        res_valid <= s1_valid;
      end
      if (~op_stall) begin
        s1_valid <= op_valid;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (op_valid && !op_stall) begin
      op_q <= op;
    end
    if (out_ready && s1_valid) begin
      res <= alu_res;
    end
  end

  cas_alu u_alu (
    .op  (op_q),
    .res (alu_res)
  );

  // An accepted operation always occupies the input register next cycle
  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> s1_valid)
    else $error("accepted operation lost from input register");

  // A waiting operation moves into the result register once it frees up
  a_advance : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_ready) |=> res_valid)
    else $error("operation did not advance to result register");

  // Register and memory write-back never occur together
  a_one_target : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.reg_write && res.mem_write))
    else $error("result writes both register and memory");

  // Memory value is zero unless a memory write is requested
  a_mem_clear : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.mem_write) |-> (res.mem_value == 8'h00))
    else $error("memory value set without memory write");

endmodule

// File: rtl/core/cas_bcd.sv
// Packed BCD adder/subtractor with digit check and decimal overflow rule.
// Depends on cas_pkg.
module cas_bcd (
  input  logic              [7:0] a,
  input  logic              [7:0] b,
  input  logic                    cin,
  input  logic                    sub,
  output cas_pkg::bcd_res_t       bcd
);
  import cas_pkg::*;

  logic [3:0] a_hi, a_lo, b_hi, b_lo;
  logic [4:0] lo_raw, hi_raw;
  logic       lo_c, hi_c;
  logic [3:0] lo_d, hi_d;
  logic [6:0] a_val, b_val;
  logic [7:0] sum_val;
  logic [7:0] diff_val;

  assign a_hi = a[7:4];
  assign a_lo = a[3:0];
  assign b_hi = b[7:4];
  assign b_lo = b[3:0];

  assign bcd.ok = (a_hi <= BCD_MAX) && (a_lo <= BCD_MAX) &&
                  (b_hi <= BCD_MAX) && (b_lo <= BCD_MAX);

  // Decimal values of the operands: hi*10 + lo
  assign a_val = {a_hi, 3'b000} + {2'b00, a_hi, 1'b0} + {3'b000, a_lo};
  assign b_val = {b_hi, 3'b000} + {2'b00, b_hi, 1'b0} + {3'b000, b_lo};

  always_comb begin
    if (sub) begin
      // borrow in is the inverse of carry
      lo_raw = {1'b0, a_lo} - {1'b0, b_lo} - {4'b0000, ~cin};
      lo_c   = lo_raw[4];
      lo_d   = lo_c ? 4'(lo_raw + BCD_RADIX) : lo_raw[3:0];
      hi_raw = {1'b0, a_hi} - {1'b0, b_hi} - {4'b0000, lo_c};
      hi_c   = hi_raw[4];
      hi_d   = hi_c ? 4'(hi_raw + BCD_RADIX) : hi_raw[3:0];
    end else begin
      lo_raw = {1'b0, a_lo} + {1'b0, b_lo} + {4'b0000, cin};
      lo_c   = (lo_raw >= BCD_RADIX);
      lo_d   = lo_c ? 4'(lo_raw - BCD_RADIX) : lo_raw[3:0];
      hi_raw = {1'b0, a_hi} + {1'b0, b_hi} + {4'b0000, lo_c};
      hi_c   = (hi_raw >= BCD_RADIX);
      hi_d   = hi_c ? 4'(hi_raw - BCD_RADIX) : hi_raw[3:0];
    end
  end

  assign bcd.value = {hi_d, lo_d};

  // Carry set at sum >= 100; for subtract, set when no borrow out
  assign bcd.carry = sub ? ~hi_c : hi_c;

  // Unreduced decimal sum and the adjusted difference, for V
  assign sum_val  = {1'b0, a_val} + {1'b0, b_val} + {7'b0000000, cin};
  assign diff_val = {1'b0, hi_d, 3'b000} + {3'b000, hi_d, 1'b0} + {4'b0000, lo_d};

  assign bcd.ovf = sub ? ((a[7] ^ diff_val[7]) & (a[7] ^ bcd.value[7]))
                       : ((a[7] ^ sum_val[7])  & (a[7] ^ bcd.value[7]));

endmodule

// File: rtl/core/cas_alu.sv
// Operation decode and result selection for one arithmetic step.
// Depends on cas_pkg and cas_bcd.
module cas_alu (
  input  cas_pkg::op_t  op,
  output cas_pkg::res_t res
);
  import cas_pkg::*;

  logic       c_in;
  logic       dec;
  logic [8:0] bin_add;
  logic [8:0] bin_sub;
  logic [8:0] cmp_sub;
  logic [7:0] r_inc, r_dec, m_inc, m_dec;
  bcd_res_t   bcd;

  assign c_in = op.status_in[FLAG_C];
  assign dec  = op.status_in[FLAG_D];

  assign bin_add = {1'b0, op.reg_in} + {1'b0, op.operand} + {8'h00, c_in};
  assign bin_sub = {1'b0, op.reg_in} - {1'b0, op.operand} - {8'h00, ~c_in};
  assign cmp_sub = {1'b0, op.reg_in} - {1'b0, op.operand};
  assign r_inc   = op.reg_in + 8'd1;
  assign r_dec   = op.reg_in - 8'd1;
  assign m_inc   = op.operand + 8'd1;
  assign m_dec   = op.operand - 8'd1;

  cas_bcd u_bcd (
    .a   (op.reg_in),
    .b   (op.operand),
    .cin (c_in),
    .sub (op.mode == MODE_SBC),
    .bcd (bcd)
  );

  always_comb begin
    res.reg_out    = op.reg_in;
    res.reg_write  = 1'b0;
    res.mem_value  = 8'h00;
    res.mem_write  = 1'b0;
    res.status_out = op.status_in;
    case (op.mode)
      MODE_ADC, MODE_SBC: begin
        if (dec) begin
          // invalid digit: leave everything unchanged
          if (bcd.ok) begin
            res.reg_out            = bcd.value;
            res.reg_write          = 1'b1;
            res.status_out[FLAG_V] = bcd.ovf;
            res.status_out[FLAG_C] = bcd.carry;
            res.status_out[FLAG_Z] = (bcd.value == 8'h00);
          end
        end else if (op.mode == MODE_ADC) begin
          res.reg_out            = bin_add[7:0];
          res.reg_write          = 1'b1;
          res.status_out[FLAG_N] = bin_add[7];
          res.status_out[FLAG_Z] = (bin_add[7:0] == 8'h00);
          res.status_out[FLAG_V] = (op.reg_in[7] ^ bin_add[7]) &
                                   (op.operand[7] ^ bin_add[7]);
          res.status_out[FLAG_C] = bin_add[8];
        end else begin
          res.reg_out            = bin_sub[7:0];
          res.reg_write          = 1'b1;
          res.status_out[FLAG_N] = bin_sub[7];
          res.status_out[FLAG_Z] = (bin_sub[7:0] == 8'h00);
          res.status_out[FLAG_V] = (op.reg_in[7] ^ op.operand[7]) &
                                   (op.reg_in[7] ^ bin_sub[7]);
          res.status_out[FLAG_C] = ~bin_sub[8];
        end
      end
      MODE_CMP, MODE_CPX, MODE_CPY: begin
        res.status_out[FLAG_N] = cmp_sub[7];
        res.status_out[FLAG_Z] = (cmp_sub[7:0] == 8'h00);
        res.status_out[FLAG_C] = ~cmp_sub[8];
      end
      MODE_INCMEM, MODE_DECMEM: begin
        res.mem_value          = (op.mode == MODE_INCMEM) ? m_inc : m_dec;
        res.mem_write          = 1'b1;
        res.status_out[FLAG_N] = res.mem_value[7];
        res.status_out[FLAG_Z] = (res.mem_value == 8'h00);
      end
      MODE_INCACC, MODE_INX, MODE_INY: begin
        res.reg_out            = r_inc;
        res.reg_write          = 1'b1;
        res.status_out[FLAG_N] = r_inc[7];
        res.status_out[FLAG_Z] = (r_inc == 8'h00);
      end
      MODE_DECACC, MODE_DEX, MODE_DEY: begin
        res.reg_out            = r_dec;
        res.reg_write          = 1'b1;
        res.status_out[FLAG_N] = r_dec[7];
        res.status_out[FLAG_Z] = (r_dec == 8'h00);
      end
      default: begin
        // unused selector: write nothing, pass status through
        res.reg_out = op.reg_in;
      end
    endcase
  end

endmodule

// File: verif/tb_cpu_arith_alu_step_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for cpu_arith_alu_step_top: directed and random ALU operations,
// each result checked field by field against a behavioural predictor under handshake pressure.
// Depends on cas_pkg and the RTL under rtl/core.
module tb_cpu_arith_alu_step_top;
  import cas_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 11;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int DRAIN_CYCLES     = 4;     // two-stage pipe, plus margin
  localparam int QUIET_LIMIT      = 1000;  // cycles with no transfer on either side
  localparam int DEC_WRAP         = 100;   // decimal carry point

  // highest selector code; codes above MODE_DEY are unused
  localparam logic [3:0] MODE_TOP = 4'hf;

  localparam logic [7:0] P_C = 8'(1) << FLAG_C;
  localparam logic [7:0] P_D = 8'(1) << FLAG_D;
  localparam logic [7:0] P_N = 8'(1) << FLAG_N;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  op_valid  = 1'b0;
  logic  op_stall;
  op_t   op        = '0;
  logic  res_valid;
  logic  res_stall = 1'b0;
  res_t  res;

  op_t   pending_ops[$];       // operations not yet offered to the block
  res_t  expected_results[$];  // predictions for transferred operations, oldest first

  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    quiet_cycles   = 0;
  int    fail_count     = 0;
  int    ops_sent       = 0;
  int    results_checked = 0;
  int    decimal_ops    = 0;
  int    bad_digit_ops  = 0;

  cpu_arith_alu_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic bcd_digits_ok(logic [7:0] b);
    return (b[7:4] <= BCD_MAX) && (b[3:0] <= BCD_MAX);
  endfunction

  function automatic int bcd_value(logic [7:0] b);
    return int'(b[7:4]) * int'(BCD_RADIX) + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_packed_bcd(int v);
    return {4'(v / int'(BCD_RADIX)), 4'(v % int'(BCD_RADIX))};
  endfunction

  // Work out the result of one ALU operation.
  function automatic res_t predict_alu_step(op_t a);
    res_t       r;
    logic [7:0] acc;
    logic [7:0] m;
    logic [7:0] p;
    logic [7:0] val;
    logic [8:0] wide;
    logic       cin;
    logic       nz;
    int         dec;
    acc = a.reg_in;
    m   = a.operand;
    p   = a.status_in;
    cin = p[FLAG_C];
    val = '0;
    nz  = 1'b0;
    r   = '0;
    r.reg_out = acc;
    case (a.mode)
      MODE_ADC, MODE_SBC: begin
        if (p[FLAG_D]) begin
          // a non-BCD digit leaves register and status untouched
          if (bcd_digits_ok(acc) && bcd_digits_ok(m)) begin
            if (a.mode == MODE_ADC) begin
              dec = bcd_value(acc) + bcd_value(m) + int'(cin);
              p[FLAG_C] = dec >= DEC_WRAP;
              val = to_packed_bcd(dec % DEC_WRAP);
            end else begin
              dec = bcd_value(acc) - bcd_value(m) - int'(!cin);
              p[FLAG_C] = dec >= 0;
              if (dec < 0) dec += DEC_WRAP;
              val = to_packed_bcd(dec);
            end
            // V from bit 7 of the raw sum or adjusted difference; N is left alone
            p[FLAG_V] = (acc[7] ^ dec[7]) & (acc[7] ^ val[7]);
            p[FLAG_Z] = (val == '0);
            r.reg_out   = val;
            r.reg_write = 1'b1;
          end
        end else begin
          if (a.mode == MODE_ADC) begin
            wide = {1'b0, acc} + {1'b0, m} + 9'(cin);
            p[FLAG_V] = (acc[7] ^ wide[7]) & (m[7] ^ wide[7]);
            p[FLAG_C] = wide[8];
          end else begin
            wide = {1'b0, acc} - {1'b0, m} - 9'(!cin);
            p[FLAG_V] = (acc[7] ^ m[7]) & (acc[7] ^ wide[7]);
            p[FLAG_C] = !wide[8];
          end
          val = wide[7:0];
          nz  = 1'b1;
          r.reg_out   = val;
          r.reg_write = 1'b1;
        end
      end
      MODE_CMP, MODE_CPX, MODE_CPY: begin
        val = acc - m;
        nz  = 1'b1;
        p[FLAG_C] = acc >= m;
      end
      MODE_INCMEM, MODE_DECMEM: begin
        val = (a.mode == MODE_INCMEM) ? m + 8'd1 : m - 8'd1;
        nz  = 1'b1;
        r.mem_value = val;
        r.mem_write = 1'b1;
      end
      MODE_INCACC, MODE_INX, MODE_INY, MODE_DECACC, MODE_DEX, MODE_DEY: begin
        val = (a.mode == MODE_DECACC || a.mode == MODE_DEX || a.mode == MODE_DEY) ?
              acc - 8'd1 : acc + 8'd1;
        nz  = 1'b1;
        r.reg_out   = val;
        r.reg_write = 1'b1;
      end
      default: ;
    endcase
    if (nz) begin
      p[FLAG_N] = val[7];
      p[FLAG_Z] = (val == '0);
    end
    r.status_out = p;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic op_t mk_op(logic [3:0] mode, logic [7:0] reg_in, logic [7:0] operand,
                                logic [7:0] status_in);
    op_t o;
    o.mode      = mode;
    o.reg_in    = reg_in;
    o.operand   = operand;
    o.status_in = status_in;
    return o;
  endfunction

  // Bias one byte in five towards the sign and wrap boundaries.
  function automatic logic [7:0] corner_byte();
    logic [7:0] corners [6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
    if ($urandom_range(99) < 20) return corners[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] bcd_byte();
    return {4'($urandom_range(BCD_MAX)), 4'($urandom_range(BCD_MAX))};
  endfunction

  // Add/subtract as the largest share, with decimal mode usually on well-formed BCD; then
  // compares, inc/dec, and a sprinkling of unused selector codes.
  function automatic op_t make_random_op();
    op_t o;
    int  pick;
    pick        = $urandom_range(99);
    o.status_in = 8'($urandom);
    o.operand   = corner_byte();
    o.reg_in    = corner_byte();
    if (pick < 40) begin
      o.mode = $urandom_range(1) ? MODE_SBC : MODE_ADC;
      o.status_in[FLAG_D] = $urandom_range(99) < 55;
      if (o.status_in[FLAG_D] && $urandom_range(99) < 85) begin
        o.operand = bcd_byte();
        o.reg_in  = bcd_byte();
      end
    end else if (pick < 55) begin
      o.mode = 4'($urandom_range(MODE_CPY, MODE_CMP));
      if ($urandom_range(3) == 0) o.operand = o.reg_in;
    end else if (pick < 93) begin
      o.mode = 4'($urandom_range(MODE_DEY, MODE_INCMEM));
    end else begin
      o.mode = 4'($urandom_range(MODE_TOP, MODE_DEY + 1));
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_result(res_t want, res_t got);
    if (got.reg_out !== want.reg_out) begin
      $error("reg_out: expected %02h, got %02h", want.reg_out, got.reg_out);
      fail_count++;
    end
    if (got.reg_write !== want.reg_write) begin
      $error("reg_write: expected %0b, got %0b", want.reg_write, got.reg_write);
      fail_count++;
    end
    if (got.mem_value !== want.mem_value) begin
      $error("mem_value: expected %02h, got %02h", want.mem_value, got.mem_value);
      fail_count++;
    end
    if (got.mem_write !== want.mem_write) begin
      $error("mem_write: expected %0b, got %0b", want.mem_write, got.mem_write);
      fail_count++;
    end
    if (got.status_out !== want.status_out) begin
      $error("status_out: expected %08b, got %08b", want.status_out, got.status_out);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: record the transfer that completes at this edge, then offer the
  // next operation unless the sender idles. Hold the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && !op_stall) begin
        expected_results.push_back(predict_alu_step(op));
        ops_sent++;
        if ((op.mode == MODE_ADC || op.mode == MODE_SBC) && op.status_in[FLAG_D]) begin
          decimal_ops++;
          if (!(bcd_digits_ok(op.reg_in) && bcd_digits_ok(op.operand))) bad_digit_ops++;
        end
      end
      if (!op_valid || !op_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op       <= pending_ops.pop_front();
          op_valid <= 1'b1;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction, then
  // decide whether to stall the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: %p", res);
          fail_count++;
        end else begin
          check_result(expected_results.pop_front(), res);
        end
        results_checked++;
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up once neither channel has moved for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (op_valid && !op_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $error("no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then three pressure phases. Queue changes happen on the
  // falling edge so the driver never races them.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin
          send_idle_pct  = 7;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // binary add: signed overflow, carry-in wrapping to zero, both negative
        pending_ops.push_back(mk_op(MODE_ADC, 8'h7f, 8'h01, '0));
        pending_ops.push_back(mk_op(MODE_ADC, 8'hff, 8'h00, P_C));
        pending_ops.push_back(mk_op(MODE_ADC, 8'h80, 8'h80, P_N));
        // decimal add: exact wrap to 00, largest sum, ordinary carry
        pending_ops.push_back(mk_op(MODE_ADC, 8'h99, 8'h01, P_D));
        pending_ops.push_back(mk_op(MODE_ADC, 8'h99, 8'h99, P_D | P_C));
        pending_ops.push_back(mk_op(MODE_ADC, 8'h58, 8'h46, P_D | P_C));
        // decimal add with a non-BCD digit: nothing changes
        pending_ops.push_back(mk_op(MODE_ADC, 8'h1a, 8'h01, P_D | P_N));
        // binary subtract: borrow to ff, signed overflow
        pending_ops.push_back(mk_op(MODE_SBC, 8'h00, 8'h01, P_C));
        pending_ops.push_back(mk_op(MODE_SBC, 8'h80, 8'h01, P_C));
        // decimal subtract: borrow past zero, plain difference
        pending_ops.push_back(mk_op(MODE_SBC, 8'h00, 8'h01, P_D | P_C));
        pending_ops.push_back(mk_op(MODE_SBC, 8'h46, 8'h12, P_D | P_C));
        // decimal subtract with a non-BCD digit in the operand
        pending_ops.push_back(mk_op(MODE_SBC, 8'h50, 8'hf0, P_D));
        // compares: equal, below, top against bottom
        pending_ops.push_back(mk_op(MODE_CMP, 8'h40, 8'h40, '0));
        pending_ops.push_back(mk_op(MODE_CPX, 8'h10, 8'h20, P_C));
        pending_ops.push_back(mk_op(MODE_CPY, 8'hff, 8'h00, '0));
        // increments and decrements across the wrap and sign boundaries
        pending_ops.push_back(mk_op(MODE_INCMEM, 8'h00, 8'hff, '0));
        pending_ops.push_back(mk_op(MODE_DECMEM, 8'h55, 8'h00, '0));
        pending_ops.push_back(mk_op(MODE_INCACC, 8'h7f, 8'h00, '0));
        pending_ops.push_back(mk_op(MODE_DECACC, 8'h01, 8'h00, P_N));
        pending_ops.push_back(mk_op(MODE_INX, 8'hff, 8'h00, '0));
        pending_ops.push_back(mk_op(MODE_INY, 8'h00, 8'h00, 8'hff));
        pending_ops.push_back(mk_op(MODE_DEX, 8'h80, 8'h00, '0));
        pending_ops.push_back(mk_op(MODE_DEY, 8'h00, 8'h00, '0));
        // unused selector: status passes straight through
        pending_ops.push_back(mk_op(MODE_DEY + 4'd1, 8'h33, 8'hcc, 8'hff));
      end

      repeat (RANDOM_PER_PHASE) pending_ops.push_back(make_random_op());

      // advance once the queue is empty and the last offer has been taken
      while (pending_ops.size() != 0 || op_valid) @(negedge clk);
    end

    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d operations, %0d of them decimal add/subtract",
             results_checked, ops_sent, decimal_ops);
    $display("(%0d with a non-BCD digit), under sender, receiver and no back-pressure.",
             bad_digit_ops);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: cpu_arith_alu_step_top.f
rtl/core/cas_pkg.sv
rtl/core/cas_bcd.sv
rtl/core/cas_alu.sv
rtl/core/cpu_arith_alu_step_top.sv
verif/tb_cpu_arith_alu_step_top.sv
